/* hw/rtl/nmea_rmc_position_extractor_unit_defines.svh */
// Assertion helpers for the port checker of this block.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef NMEA_RMC_POSITION_EXTRACTOR_UNIT_DEFINES_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NRMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nrmc assertion failed");

// Next-cycle implication.
`define NRMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nrmc assertion failed");

`endif

/* hw/rtl/nrmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position extractor package
// Character codes, line layout constants, the walk program table and the
// record type for display line writes.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	localparam int unsigned DEF_PACKET_BYTES = 64;
	localparam int unsigned LINE_CHARS       = 16;
	localparam int unsigned LINE_IDX_W       = 5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [4:0] LAST_INDEX = 5'd31;

	typedef enum logic [2:0] {
		OP_SCAN   = 3'd0,
		OP_STATUS = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_COPY   = 3'd3,
		OP_PUT    = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [5:0]  from;
		logic [5:0]  to;
	} op_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  addr;
		logic [7:0]  data;
	} line_wr_t;

	localparam logic [3:0] OP_LAST = 4'd13;

	// Walk program. Line addresses 0-15 are the latitude line, 16-31 the
	// longitude line. A copy fills slots from..to-1 at most, stopping at a comma.
	function automatic op_t nrmc_op(input logic [3:0] pc);
		op_t op;
		op = '{kind: OP_SCAN, from: 6'd0, to: 6'd0};
		case (pc)
			4'd0:    op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd1:    op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd2:    op = '{kind: OP_STATUS, from: 6'd15, to: 6'd0};
			4'd3:    op = '{kind: OP_CLEAR,  from: 6'd0,  to: 6'd32};
			4'd4:    op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd5:    op = '{kind: OP_COPY,   from: 6'd4,  to: 6'd6};
			4'd6:    op = '{kind: OP_COPY,   from: 6'd7,  to: 6'd16};
			4'd7:    op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd8:    op = '{kind: OP_PUT,    from: 6'd15, to: 6'd0};
			4'd9:    op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd10:   op = '{kind: OP_COPY,   from: 6'd20, to: 6'd23};
			4'd11:   op = '{kind: OP_COPY,   from: 6'd24, to: 6'd32};
			4'd12:   op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
			4'd13:   op = '{kind: OP_PUT,    from: 6'd31, to: 6'd0};
			default: op = '{kind: OP_SCAN,   from: 6'd0,  to: 6'd0};
		endcase
		return op;
	endfunction

	// Character written by the clearing sweep: the line prefixes, else space.
	function automatic logic [7:0] nrmc_clear_char(input logic [4:0] idx);
		logic [7:0] ch;
		ch = CH_SPACE;
		case (idx)
			5'd0:    ch = 8'h4C;
			5'd1:    ch = 8'h61;
			5'd2:    ch = 8'h74;
			5'd3:    ch = 8'h3A;
			5'd16:   ch = 8'h4C;
			5'd17:   ch = 8'h6F;
			5'd18:   ch = 8'h6E;
			5'd19:   ch = 8'h3A;
			default: ch = CH_SPACE;
		endcase
		return ch;
	endfunction

endpackage

/* hw/rtl/nmea_rmc_position_extractor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position extractor
// Collects the bytes after each '$', walks RMC sentences to rebuild the
// latitude and longitude display lines, and sends out all 32 characters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  rx_byte
// output    out        out_valid/out_stall display_index, display_char, last_char
//
// Bytes are taken one per cycle while the block hunts for '$' and collects.
// The last byte of an RMC packet starts the walker, which inspects packet bytes
// through the packet memory read port and, for a valid fix, runs a sweep over all
// 32 line slots. Then 32 characters leave at one per cycle unless out_stall holds
// them; in_stall stays high from the last packet byte until the final character
// is loaded into the output. Reset sets both display lines to spaces; the packet
// memory is not cleared.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_unit #(
	parameter int unsigned PACKET_BYTES = nrmc_pkg::DEF_PACKET_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  display_index,
	output logic [7:0]  display_char,
	output logic        last_char
);
	import nrmc_pkg::*;

	localparam int unsigned AW = $clog2(PACKET_BYTES);
	localparam int unsigned PW = $clog2(PACKET_BYTES + 1);

	typedef enum logic [2:0] {
		S_COLLECT = 3'b001,
		S_WALK    = 3'b010,
		S_EMIT    = 3'b100
	} state_t;

	state_t        state_q;
	logic [PW-1:0] cnt_q;
	logic          is_m_q;
	logic          is_c_q;
	logic [7:0]    line_q [2*LINE_CHARS];
	logic [4:0]    emit_k_q;
	logic          out_valid_q;
	logic [4:0]    index_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic          acc;
	logic          storing;
	logic [PW-1:0] cnt_m1;
	logic [AW-1:0] wr_addr;
	logic          start;
	logic          walk_done;
	logic          load;
	line_wr_t      line_wr;

	assign in_stall = (state_q != S_COLLECT);
	assign acc      = in_valid && !in_stall;
	// A nonzero count k means k-1 packet bytes are already stored.
	assign storing  = acc && (cnt_q != '0);
	assign cnt_m1   = cnt_q - PW'(1);
	assign wr_addr  = cnt_m1[AW-1:0];
	assign start    = storing && (cnt_q == PW'(PACKET_BYTES)) && is_m_q && is_c_q;
	assign load     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	nrmc_walker #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (storing),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.start   (start),
		.line_wr (line_wr),
		.done    (walk_done)
	);

	always_ff @(posedge clk) begin
		if (storing && wr_addr == AW'(3)) begin
			is_m_q <= (rx_byte == CH_M);
		end
		if (storing && wr_addr == AW'(4)) begin
			is_c_q <= (rx_byte == CH_C);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 2 * LINE_CHARS; j++) begin
				line_q[j] <= CH_SPACE;
			end
		end else if (line_wr.we) begin
			line_q[line_wr.addr] <= line_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			cnt_q       <= '0;
			emit_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_COLLECT: begin
					if (acc) begin
						if (cnt_q == '0) begin
							if (rx_byte == CH_DOLLAR) begin
								cnt_q <= PW'(1);
							end
						end else if (cnt_q == PW'(PACKET_BYTES)) begin
							cnt_q <= '0;
							if (start) begin
								state_q <= S_WALK;
							end
						end else begin
							cnt_q <= cnt_q + PW'(1);
						end
					end
				end
				S_WALK: begin
					if (walk_done) begin
						emit_k_q <= '0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						emit_k_q <= emit_k_q + 5'd1;
						if (emit_k_q == LAST_INDEX) begin
							state_q <= S_COLLECT;
						end
					end
				end
				default: state_q <= S_COLLECT;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			index_q <= emit_k_q;
			char_q  <= line_q[emit_k_q];
			last_q  <= (emit_k_q == LAST_INDEX);
		end
	end

	assign out_valid     = out_valid_q;
	assign display_index = index_q;
	assign display_char  = char_q;
	assign last_char     = last_q;

endmodule

/* hw/rtl/nrmc_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC packet walker
// Holds the packet bytes and runs the field walk program over them with byte
// compares for comma and fix status and a packet pointer, emitting display line writes.
// ----------------------------------------------------------------------------
module nrmc_walker #(
	parameter int unsigned PACKET_BYTES = nrmc_pkg::DEF_PACKET_BYTES,
	localparam int unsigned AW = $clog2(PACKET_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [7:0]          wr_data,
	input  logic                start,
	output nrmc_pkg::line_wr_t  line_wr,
	output logic                done
);
	import nrmc_pkg::*;

	localparam int unsigned PW = $clog2(PACKET_BYTES + 1);

	typedef enum logic [2:0] {
		W_IDLE = 3'b001,
		W_OP   = 3'b010,
		W_EVAL = 3'b100
	} wstate_t;

	logic [7:0]    mem [PACKET_BYTES];
	logic [7:0]    rd_q;
	wstate_t       state_q, state_n;
	logic [3:0]    pc_q, pc_n;
	logic [PW-1:0] pos_q, pos_n;
	logic [5:0]    i_q, i_n;
	logic [AW-1:0] rd_addr;
	logic          pos_end;
	logic [7:0]    cur_byte;
	logic          is_comma;
	logic          advance;
	op_t           op;
	op_t           op_next;
	op_t           op_first;

	assign pos_end  = (pos_q == PW'(PACKET_BYTES));
	assign rd_addr  = pos_end ? '0 : pos_q[AW-1:0];
	// Positions at or past the end of the packet read as a comma.
	assign cur_byte = pos_end ? CH_COMMA : rd_q;
	assign is_comma = (cur_byte == CH_COMMA);
	assign op       = nrmc_op(pc_q);
	assign op_next  = nrmc_op(pc_q + 4'd1);
	assign op_first = nrmc_op(4'd0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_n = state_q;
		pc_n    = pc_q;
		pos_n   = pos_q;
		i_n     = i_q;
		line_wr = '0;
		done    = 1'b0;
		advance = 1'b0;
		case (state_q)
			W_IDLE: begin
				if (start) begin
					pc_n    = '0;
					pos_n   = '0;
					i_n     = op_first.from;
					state_n = W_OP;
				end
			end
			W_OP: begin
				case (op.kind)
					OP_CLEAR: begin
						line_wr.we   = 1'b1;
						line_wr.addr = i_q[4:0];
						line_wr.data = nrmc_clear_char(i_q[4:0]);
						i_n          = i_q + 6'd1;
						if (i_q + 6'd1 == op.to) begin
							advance = 1'b1;
						end
					end
					OP_COPY: begin
						if (i_q >= op.to) begin
							advance = 1'b1;
						end else begin
							state_n = W_EVAL;
						end
					end
					default: state_n = W_EVAL;
				endcase
			end
			W_EVAL: begin
				case (op.kind)
					OP_SCAN: begin
						if (pos_end) begin
							advance = 1'b1;
						end else begin
							pos_n = pos_q + PW'(1);
							if (is_comma) begin
								advance = 1'b1;
							end else begin
								state_n = W_OP;
							end
						end
					end
					OP_STATUS: begin
						if (cur_byte != CH_A) begin
							line_wr.we   = 1'b1;
							line_wr.addr = op.from[4:0];
							line_wr.data = cur_byte;
							done         = 1'b1;
							state_n      = W_IDLE;
						end else begin
							advance = 1'b1;
						end
					end
					OP_COPY: begin
						if (is_comma) begin
							advance = 1'b1;
						end else begin
							line_wr.we   = 1'b1;
							line_wr.addr = i_q[4:0];
							line_wr.data = cur_byte;
							i_n          = i_q + 6'd1;
							pos_n        = pos_q + PW'(1);
							state_n      = W_OP;
						end
					end
					OP_PUT: begin
						line_wr.we   = 1'b1;
						line_wr.addr = op.from[4:0];
						line_wr.data = cur_byte;
						advance      = 1'b1;
					end
					default: state_n = W_IDLE;
				endcase
			end
			default: state_n = W_IDLE;
		endcase
		if (advance) begin
			if (pc_q == OP_LAST) begin
				done    = 1'b1;
				state_n = W_IDLE;
			end else begin
				pc_n    = pc_q + 4'd1;
				i_n     = op_next.from;
				state_n = W_OP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			pc_q    <= '0;
			pos_q   <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_n;
			pc_q    <= pc_n;
			pos_q   <= pos_n;
			i_q     <= i_n;
		end
	end

endmodule

/* hw/rtl/nrmc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position extractor port checker
// Watches the top level ports for ordering of the emitted character run.
// ----------------------------------------------------------------------------
`include "nmea_rmc_position_extractor_unit_defines.svh"

module nrmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  display_index,
	input logic [7:0]  display_char,
	input logic        last_char
);

	// A held transaction keeps its payload.
	`NRMC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(display_index) && $stable(display_char) && $stable(last_char))

	// The last flag marks only the final longitude character.
	`NRMC_ASSERT_IMP(a_last_pos, clk, arst_n, out_valid && last_char, display_index == 5'd31)

	// Characters of a run follow in order without gaps.
	`NRMC_ASSERT_NXT(a_run_order, clk, arst_n, out_valid && !out_stall && !last_char, out_valid && (display_index == $past(display_index) + 5'd1))

	// No byte is taken while a run is still being sent.
	`NRMC_ASSERT_IMP(a_busy_stall, clk, arst_n, out_valid && !last_char, in_stall)

endmodule

bind nmea_rmc_position_extractor_unit nrmc_checker u_nrmc_checker (.*);

/* verif/nmea_rmc_position_extractor_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position extractor checker
// Watches both channels, rebuilds the two display lines from every accepted
// byte and compares each emitted character with the oldest predicted one.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [4:0] display_index,
	input  logic [7:0] display_char,
	input  logic       last_char,
	output int         mismatch_count,
	output int         chars_due
);
	import nrmc_pkg::*;

	localparam int PKT = DEF_PACKET_BYTES;
	localparam int SCREEN_CHARS = 2 * LINE_CHARS;
	localparam logic [31:0] LAT_TAG = "Lat:";
	localparam logic [31:0] LON_TAG = "Lon:";

	typedef struct packed {
		logic [4:0] index;
		logic [7:0] code;
		logic       last;
	} screen_char_t;

	screen_char_t due_chars[$];
	screen_char_t got;
	screen_char_t want;
	logic [7:0]   sentence[PKT];
	logic [7:0]   screen[SCREEN_CHARS];
	int           fill_level;
	int           errors;

	// Positions at or past the end of the sentence read as a comma.
	function automatic logic [7:0] sentence_at(int pos);
		if (pos >= PKT)
			return CH_COMMA;
		return sentence[pos];
	endfunction

	function automatic int past_comma(int pos);
		int p;
		for (p = pos; p < PKT; p++)
			if (sentence[p] == CH_COMMA)
				return p + 1;
		return PKT;
	endfunction

	function automatic int copy_run(int first, int stop, int pos);
		int slot;
		int p;
		p = pos;
		for (slot = first; slot < stop && sentence_at(p) != CH_COMMA; slot++) begin
			screen[slot] = sentence_at(p);
			p++;
		end
		return p;
	endfunction

	task automatic rebuild_position();
		int pos;
		logic [7:0] fix;
		pos = past_comma(past_comma(0));
		fix = sentence_at(pos);
		if (fix != CH_A) begin
			// Without a valid fix only the tail of the latitude line shows the status.
			screen[LINE_CHARS - 1] = fix;
		end else begin
			for (int i = 0; i < SCREEN_CHARS; i++)
				screen[i] = CH_SPACE;
			for (int i = 0; i < 4; i++) begin
				screen[i] = LAT_TAG[31 - 8 * i -: 8];
				screen[LINE_CHARS + i] = LON_TAG[31 - 8 * i -: 8];
			end
			pos = past_comma(pos);
			pos = copy_run(4, 6, pos);
			pos = copy_run(7, LINE_CHARS, pos);
			pos = past_comma(pos);
			screen[LINE_CHARS - 1] = sentence_at(pos);
			pos = past_comma(pos);
			pos = copy_run(LINE_CHARS + 4, LINE_CHARS + 7, pos);
			pos = copy_run(LINE_CHARS + 8, SCREEN_CHARS, pos);
			pos = past_comma(pos);
			screen[SCREEN_CHARS - 1] = sentence_at(pos);
		end
	endtask

	task automatic take_byte(input logic [7:0] b);
		screen_char_t entry;
		if (fill_level == 0) begin
			if (b == CH_DOLLAR)
				fill_level = 1;
		end else begin
			sentence[fill_level - 1] = b;
			if (fill_level < PKT) begin
				fill_level++;
			end else begin
				fill_level = 0;
				if (sentence[3] == CH_M && sentence[4] == CH_C) begin
					rebuild_position();
					for (int k = 0; k < SCREEN_CHARS; k++) begin
						entry.index = k[4:0];
						entry.code  = screen[k];
						entry.last  = (k == SCREEN_CHARS - 1);
						due_chars.push_back(entry);
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_level = 0;
			errors = 0;
			due_chars.delete();
			for (int i = 0; i < SCREEN_CHARS; i++)
				screen[i] = CH_SPACE;
			mismatch_count <= 0;
			chars_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {display_index, display_char, last_char};
				if (due_chars.size() == 0) begin
					if (errors < 10)
						$display("unexpected output transaction: index %0d char %h last %b",
							got.index, got.code, got.last);
					errors++;
				end else begin
					want = due_chars.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch: expected index %0d char %h last %b, got index %0d char %h last %b",
								want.index, want.code, want.last,
								got.index, got.code, got.last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				take_byte(rx_byte);
			mismatch_count <= errors;
			chars_due <= due_chars.size();
		end
	end

endmodule

/* verif/nmea_rmc_position_extractor_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position extractor testbench
// Feeds directed and randomized NMEA sentences with random idle gaps on both
// channels, lets the checker predict and compare, and reports the verdict.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_unit_test;
	import nrmc_pkg::*;

	localparam int PKT = DEF_PACKET_BYTES;
	localparam int ITEM_TARGET = 410;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_AT_CHAR = 100;
	localparam int HOLD_CYCLES = 400;

	localparam logic [7:0] HEM_N = "N";
	localparam logic [7:0] HEM_S = "S";
	localparam logic [7:0] HEM_E = "E";
	localparam logic [7:0] HEM_W = "W";
	localparam logic [7:0] FIX_VOID = "V";
	localparam logic [7:0] DOT = ".";
	localparam logic [7:0] DIGIT_0 = "0";
	localparam logic [7:0] LETTER_A = "A";
	localparam logic [7:0] LETTER_G = "G";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] display_index;
	logic [7:0] display_char;
	logic       last_char;
	int         mismatches;
	int         due;
	int         quiet = 0;

	logic [7:0] frame[PKT];
	int         write_ptr;
	int         stream_bytes = 0;
	bit         sender_burst;

	always #2 clk = ~clk;

	nmea_rmc_position_extractor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.display_index(display_index),
		.display_char (display_char),
		.last_char    (last_char)
	);

	nmea_rmc_position_extractor_unit_checker screen_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.display_index (display_index),
		.display_char  (display_char),
		.last_char     (last_char),
		.mismatch_count(mismatches),
		.chars_due     (due)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic offer(input logic [7:0] b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		stream_bytes++;
	endtask

	task automatic send_frame();
		sender_burst = ($urandom_range(0, 3) == 0);
		offer(CH_DOLLAR);
		for (int i = 0; i < PKT; i++)
			offer(frame[i]);
	endtask

	task automatic fill(input logic [7:0] pad);
		for (int i = 0; i < PKT; i++)
			frame[i] = pad;
		write_ptr = 0;
	endtask

	task automatic fill_random();
		for (int i = 0; i < PKT; i++)
			frame[i] = 8'($urandom_range(0, 255));
		write_ptr = 0;
	endtask

	task automatic put(input logic [7:0] b);
		if (write_ptr < PKT)
			frame[write_ptr] = b;
		write_ptr++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_digits(input int n);
		repeat (n) put(DIGIT_0 + 8'($urandom_range(0, 9)));
	endtask

	// RMC layout with random field contents and lengths, now and then with a random byte overwritten.
	task automatic build_random_rmc();
		fill_random();
		if ($urandom_range(0, 1)) begin
			put_text("GP");
		end else begin
			put(LETTER_A + 8'($urandom_range(0, 25)));
			put(LETTER_A + 8'($urandom_range(0, 25)));
		end
		put_text("RMC,");
		put_digits($urandom_range(0, 10));
		put(CH_COMMA);
		case ($urandom_range(0, 9))
			0: put(FIX_VOID);
			1: put(8'($urandom_range(0, 255)));
			2: ;
			default: put(CH_A);
		endcase
		put(CH_COMMA);
		put_digits($urandom_range(0, 5));
		if ($urandom_range(0, 1))
			put(DOT);
		put_digits($urandom_range(0, 8));
		put(CH_COMMA);
		if ($urandom_range(0, 4) != 0)
			put($urandom_range(0, 1) ? HEM_N : HEM_S);
		put(CH_COMMA);
		put_digits($urandom_range(0, 6));
		if ($urandom_range(0, 1))
			put(DOT);
		put_digits($urandom_range(0, 9));
		put(CH_COMMA);
		if ($urandom_range(0, 4) != 0)
			put($urandom_range(0, 1) ? HEM_E : HEM_W);
		put(CH_COMMA);
		if ($urandom_range(0, 9) == 0)
			frame[$urandom_range(0, PKT - 1)] = 8'($urandom_range(0, 255));
	endtask

	// Receiver: random hold-offs per character, calm stretches, and one long
	// hold-off so the block backs up and stalls its input.
	initial begin : drain
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 32 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 8);
			if (taken == HOLD_AT_CHAR)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_burst = 1'b0;

		// Noise while hunting for the start of a sentence.
		offer(8'h00);
		offer(8'hFF);
		offer(8'h0D);
		offer(8'h0A);

		fill(CH_SPACE);
		put_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
		send_frame();
		fill(8'hFF);
		put_text("GPRMC,123519,V,4807.038,N,01131.000,E,");
		send_frame();
		fill(8'h2A);
		put_text("GPGGA,123519,A,4807.038,N,01131.000,E,");
		send_frame();
		// No comma at all, with dollar signs stored as plain data.
		fill(8'h58);
		put_text("GPRMC$NO$COMMAS");
		send_frame();
		// Status in the last byte, so everything after it reads past the end.
		fill(8'h00);
		put_text("GPRMC,");
		frame[PKT - 2] = CH_COMMA;
		frame[PKT - 1] = CH_A;
		send_frame();
		// Minutes run to the end of the packet without a comma.
		fill(8'h37);
		put_text("GPRMC,,A,48");
		send_frame();

		// Random traffic until the total byte count reaches the target.
		while (stream_bytes < ITEM_TARGET) begin
			repeat ($urandom_range(0, 3)) offer(8'($urandom_range(0, 255)));
			pick = $urandom_range(0, 9);
			build_random_rmc();
			if (pick == 0) begin
				fill_random();
				if ($urandom_range(0, 1)) begin
					frame[3] = CH_M;
					frame[4] = CH_C;
				end
			end else if (pick == 1) begin
				frame[3] = LETTER_G;
				frame[4] = LETTER_A;
			end
			send_frame();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
